// ===== src/cmp_pkg.sv =====
// Shared types and constants for the CoAP message parser.
`default_nettype none
package cmp_pkg;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_TOK  = 3'd1,
    PH_OPT  = 3'd2,
    PH_DEXT = 3'd3,
    PH_LEXT = 3'd4,
    PH_VAL  = 3'd5,
    PH_PAY  = 3'd6,
    PH_IGN  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_HDR     = 3'd0,
    ROLE_TOKEN   = 3'd1,
    ROLE_OPT_HDR = 3'd2,
    ROLE_OPT_EXT = 3'd3,
    ROLE_OPT_VAL = 3'd4,
    ROLE_MARKER  = 3'd5,
    ROLE_PAYLOAD = 3'd6,
    ROLE_IGNORED = 3'd7
  } role_t;

  localparam logic [7:0]  PAYLOAD_MARKER  = 8'hFF;
  localparam logic [1:0]  COAP_VERSION    = 2'd1;
  localparam logic [3:0]  TKL_MAX         = 4'd8;
  localparam logic [3:0]  NIB_EXT1        = 4'd13;
  localparam logic [3:0]  NIB_EXT2        = 4'd14;
  localparam logic [3:0]  NIB_RESERVED    = 4'd15;
  localparam logic [16:0] EXT1_BASE       = 17'd13;
  localparam logic [16:0] EXT2_BASE       = 17'd269;
  localparam logic [15:0] URI_PATH_OPTION = 16'd11;
  localparam logic [15:0] OPT_NUM_MAX     = 16'hFFFF;
  localparam logic [10:0] PAYLOAD_SAT     = 11'h7FF;

  typedef struct packed {
    role_t       role;
    logic [7:0]  data_out;
    logic [15:0] option_number;
    logic        uri_byte;
    logic        uri_slash;
    logic        done_res;
    logic        malformed;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  request_code;
    logic [15:0] message_id;
    logic [10:0] payload_length;
  } res_t;

endpackage
`default_nettype wire

// ===== src/cmp_if.sv =====
// Valid/ready channel interfaces for datagram bytes and per-byte results.
`default_nettype none
interface cmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cmp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  role;
  logic [7:0]  data_out;
  logic [15:0] option_number;
  logic        uri_byte;
  logic        uri_slash;
  logic        done_res;
  logic        malformed;
  logic [1:0]  msg_type;
  logic [3:0]  token_length;
  logic [7:0]  request_code;
  logic [15:0] message_id;
  logic [10:0] payload_length;

  modport source (output valid, role, data_out, option_number, uri_byte, uri_slash,
                  done_res, malformed, msg_type, token_length, request_code,
                  message_id, payload_length,
                  input ready);
  modport sink   (input valid, role, data_out, option_number, uri_byte, uri_slash,
                  done_res, malformed, msg_type, token_length, request_code,
                  message_id, payload_length,
                  output ready);
endinterface
`default_nettype wire

// ===== src/coap_message_parser.sv =====
// Top level of the CoAP message parser: byte decode and result buffering.
// Throughput: one datagram byte per cycle unless the output stalls, with one
// result per byte. Each result is registered into the output register, or into
// the skid entry during a stall; the parse state updates as the byte is
// accepted. While stalled, the two-entry buffer takes just one more request.
// Reset (rst, synchronous) returns the parser to the header phase, clears all
// counters and drops both buffer entries.
`default_nettype none
module coap_message_parser #(
  parameter int URI_MAX     = 128,
  parameter int MAX_MESSAGE = 1500
) (
  input  logic clk,
  input  logic rst,
  cmp_byte_if.sink     byte_stream,
  cmp_result_if.source result_stream
);
  import cmp_pkg::*;

  res_t res;      // decode of the byte at the input
  res_t res_out;  // buffered result at the output
  logic buf_ready;
  logic accept;

  // A request is taken whenever the skid entry is free; the parser state
  // only advances on an accepted byte.
  assign byte_stream.ready = buf_ready;
  assign accept            = byte_stream.valid && buf_ready;

  cmp_parse #(
    .URI_MAX     (URI_MAX),
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (byte_stream.data_byte),
    .last_byte (byte_stream.last_byte),
    .res       (res)
  );

  cmp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .ready     (buf_ready),
    .out_valid (result_stream.valid),
    .out_ready (result_stream.ready),
    .out_data  (res_out)
  );

  // Unpack the buffered result onto the channel fields.
  assign result_stream.role           = res_out.role;
  assign result_stream.data_out       = res_out.data_out;
  assign result_stream.option_number  = res_out.option_number;
  assign result_stream.uri_byte       = res_out.uri_byte;
  assign result_stream.uri_slash      = res_out.uri_slash;
  assign result_stream.done_res       = res_out.done_res;
  assign result_stream.malformed      = res_out.malformed;
  assign result_stream.msg_type       = res_out.msg_type;
  assign result_stream.token_length   = res_out.token_length;
  assign result_stream.request_code   = res_out.request_code;
  assign result_stream.message_id     = res_out.message_id;
  assign result_stream.payload_length = res_out.payload_length;

endmodule
`default_nettype wire

// ===== src/cmp_parse.sv =====
// Parse state registers and the per-byte decode of one CoAP datagram byte.
`default_nettype none
module cmp_parse #(
  parameter int URI_MAX     = 128,
  parameter int MAX_MESSAGE = 1500
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output cmp_pkg::res_t res
);
  import cmp_pkg::*;

  localparam int UW = $clog2(URI_MAX);
  localparam int BW = $clog2(MAX_MESSAGE + 1);
  localparam logic [UW-1:0] URI_LIM  = UW'(URI_MAX - 1);
  localparam logic [BW-1:0] MSG_LIM  = BW'(MAX_MESSAGE);

  phase_t        phase, phase_next;
  logic [1:0]    header_count, header_count_next;
  logic [3:0]    token_remaining, token_remaining_next;
  logic [3:0]    delta_nibble, delta_nibble_next;
  logic [3:0]    length_nibble, length_nibble_next;
  logic [1:0]    ext_remaining, ext_remaining_next;
  logic [15:0]   ext_accum, ext_accum_next;
  logic [16:0]   value_remaining, value_remaining_next;
  logic [15:0]   last_option, last_option_next;
  logic [UW-1:0] uri_length, uri_length_next;
  logic [1:0]    msg_type, msg_type_next;
  logic [3:0]    tkl, tkl_next;
  logic [7:0]    code, code_next;
  logic [15:0]   mid, mid_next;
  logic          error_flag, error_flag_next;
  logic [10:0]   payload_count, payload_count_next;
  logic          seg_start, seg_start_next;
  logic [BW-1:0] byte_count, byte_count_next;

  // decode temporaries
  logic [15:0]   ext_acc_new;
  logic [3:0]    ext_nib, len_nib;
  logic [16:0]   ext_val, delta_d, start_len;
  logic [17:0]   opt_sum;
  logic          do_delta, do_after, do_start;
  logic          us, ub;
  logic [UW-1:0] uri_step;

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    token_remaining_next = token_remaining;
    delta_nibble_next    = delta_nibble;
    length_nibble_next   = length_nibble;
    ext_remaining_next   = ext_remaining;
    ext_accum_next       = ext_accum;
    value_remaining_next = value_remaining;
    last_option_next     = last_option;
    uri_length_next      = uri_length;
    msg_type_next        = msg_type;
    tkl_next             = tkl;
    code_next            = code;
    mid_next             = mid;
    error_flag_next      = error_flag;
    payload_count_next   = payload_count;
    seg_start_next       = seg_start;
    byte_count_next      = byte_count;

    res           = '0;
    res.role      = ROLE_IGNORED;
    res.data_out  = data_byte;

    ext_acc_new = {ext_accum[7:0], data_byte};
    ext_nib     = (phase == PH_DEXT) ? delta_nibble : length_nibble;
    ext_val     = ((ext_nib == NIB_EXT1) ? EXT1_BASE : EXT2_BASE) + {1'b0, ext_acc_new};
    delta_d     = (phase == PH_OPT) ? {13'd0, data_byte[7:4]} : ext_val;
    len_nib     = (phase == PH_OPT) ? data_byte[3:0] : length_nibble;
    opt_sum     = {2'b00, last_option} + {1'b0, delta_d};
    do_delta    = 1'b0;
    do_after    = 1'b0;
    do_start    = 1'b0;
    start_len   = ext_val;
    us          = 1'b0;
    ub          = 1'b0;
    uri_step    = uri_length;

    if (byte_count >= MSG_LIM) begin
      error_flag_next = 1'b1;
    end else begin
      byte_count_next = byte_count + 1'b1;
      unique case (phase)
        PH_HDR: begin
          res.role = ROLE_HDR;
          unique case (header_count)
            2'd0: begin
              if (data_byte[7:6] != COAP_VERSION || data_byte[3:0] > TKL_MAX) begin
                error_flag_next = 1'b1;
              end
              msg_type_next        = data_byte[5:4];
              tkl_next             = data_byte[3:0];
              code_next            = '0;
              mid_next             = '0;
              token_remaining_next = data_byte[3:0];
            end
            2'd1: code_next = data_byte;
            2'd2: mid_next[15:8] = data_byte;
            default: begin
              mid_next[7:0] = data_byte;
              if (error_flag) begin
                phase_next = PH_IGN;
              end else begin
                phase_next = (token_remaining != '0) ? PH_TOK : PH_OPT;
              end
            end
          endcase
          header_count_next = header_count + 2'd1;
        end
        PH_TOK: begin
          res.role             = ROLE_TOKEN;
          token_remaining_next = token_remaining - 4'd1;
          if (token_remaining_next == '0) begin
            phase_next = PH_OPT;
          end
        end
        PH_OPT: begin
          if (data_byte == PAYLOAD_MARKER) begin
            res.role   = ROLE_MARKER;
            phase_next = PH_PAY;
          end else begin
            res.role           = ROLE_OPT_HDR;
            delta_nibble_next  = data_byte[7:4];
            length_nibble_next = data_byte[3:0];
            if (data_byte[7:4] == NIB_RESERVED || data_byte[3:0] == NIB_RESERVED) begin
              error_flag_next = 1'b1;
              phase_next      = PH_IGN;
            end else if (data_byte[7:4] >= NIB_EXT1) begin
              ext_remaining_next = (data_byte[7:4] == NIB_EXT1) ? 2'd1 : 2'd2;
              ext_accum_next     = '0;
              phase_next         = PH_DEXT;
            end else begin
              do_delta = 1'b1;
              do_after = 1'b1;
            end
          end
        end
        PH_DEXT, PH_LEXT: begin
          res.role           = ROLE_OPT_EXT;
          ext_accum_next     = ext_acc_new;
          ext_remaining_next = ext_remaining - 2'd1;
          if (ext_remaining_next == '0) begin
            if (phase == PH_DEXT) begin
              do_delta = 1'b1;
              do_after = 1'b1;
            end else begin
              do_start = 1'b1;
            end
          end
        end
        PH_VAL: begin
          res.role = ROLE_OPT_VAL;
          if (last_option == URI_PATH_OPTION) begin
            // separator only between segments, and only while it still fits
            us       = seg_start && (uri_length != '0) && (uri_length < URI_LIM);
            uri_step = uri_length + UW'(us);
            ub       = uri_step < URI_LIM;
            uri_length_next = uri_step + UW'(ub);
          end
          seg_start_next       = 1'b0;
          value_remaining_next = value_remaining - 17'd1;
          if (value_remaining_next == '0) begin
            phase_next = PH_OPT;
          end
        end
        PH_PAY: begin
          res.role = ROLE_PAYLOAD;
          if (payload_count < PAYLOAD_SAT) begin
            payload_count_next = payload_count + 11'd1;
          end
        end
        default: res.role = ROLE_IGNORED;
      endcase
    end

    if (do_delta) begin
      last_option_next = (opt_sum > {2'b00, OPT_NUM_MAX}) ? OPT_NUM_MAX : opt_sum[15:0];
    end
    if (do_after) begin
      if (len_nib >= NIB_EXT1) begin
        ext_remaining_next = (len_nib == NIB_EXT1) ? 2'd1 : 2'd2;
        ext_accum_next     = '0;
        phase_next         = PH_LEXT;
      end else begin
        do_start  = 1'b1;
        start_len = {13'd0, len_nib};
      end
    end
    if (do_start) begin
      value_remaining_next = start_len;
      seg_start_next       = 1'b1;
      phase_next           = (start_len != '0) ? PH_VAL : PH_OPT;
    end

    res.uri_byte  = ub;
    res.uri_slash = us;
    if (res.role == ROLE_OPT_HDR || res.role == ROLE_OPT_EXT || res.role == ROLE_OPT_VAL) begin
      res.option_number = last_option_next;
    end

    if (last_byte) begin
      res.done_res       = 1'b1;
      res.malformed      = error_flag_next
                           || (phase_next != PH_OPT && phase_next != PH_PAY)
                           || (phase_next == PH_PAY && payload_count_next == '0);
      res.msg_type       = msg_type_next;
      res.token_length   = tkl_next;
      res.request_code   = code_next;
      res.message_id     = mid_next;
      res.payload_length = payload_count_next;

      phase_next           = PH_HDR;
      header_count_next    = '0;
      token_remaining_next = '0;
      delta_nibble_next    = '0;
      length_nibble_next   = '0;
      ext_remaining_next   = '0;
      ext_accum_next       = '0;
      value_remaining_next = '0;
      last_option_next     = '0;
      uri_length_next      = '0;
      msg_type_next        = '0;
      tkl_next             = '0;
      code_next            = '0;
      mid_next             = '0;
      error_flag_next      = 1'b0;
      payload_count_next   = '0;
      seg_start_next       = 1'b0;
      byte_count_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      header_count    <= '0;
      token_remaining <= '0;
      delta_nibble    <= '0;
      length_nibble   <= '0;
      ext_remaining   <= '0;
      ext_accum       <= '0;
      value_remaining <= '0;
      last_option     <= '0;
      uri_length      <= '0;
      msg_type        <= '0;
      tkl             <= '0;
      code            <= '0;
      mid             <= '0;
      error_flag      <= 1'b0;
      payload_count   <= '0;
      seg_start       <= 1'b0;
      byte_count      <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      token_remaining <= token_remaining_next;
      delta_nibble    <= delta_nibble_next;
      length_nibble   <= length_nibble_next;
      ext_remaining   <= ext_remaining_next;
      ext_accum       <= ext_accum_next;
      value_remaining <= value_remaining_next;
      last_option     <= last_option_next;
      uri_length      <= uri_length_next;
      msg_type        <= msg_type_next;
      tkl             <= tkl_next;
      code            <= code_next;
      mid             <= mid_next;
      error_flag      <= error_flag_next;
      payload_count   <= payload_count_next;
      seg_start       <= seg_start_next;
      byte_count      <= byte_count_next;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> phase == PH_HDR && header_count == '0 && !error_flag
                            && byte_count == '0)
    else $error("parser did not restart after the last byte");

  a_path_bound: assert property (@(posedge clk) disable iff (rst)
    uri_length <= URI_LIM)
    else $error("uri path length beyond limit");

  a_token_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TOK |-> token_remaining != '0)
    else $error("token phase with no token bytes left");

  a_ext_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DEXT || phase == PH_LEXT) |-> ext_remaining != '0)
    else $error("extension phase with no extension bytes left");

endmodule
`default_nettype wire

// ===== src/cmp_out_buf.sv =====
// Two-entry result buffer: output register plus a skid entry.
`default_nettype none
module cmp_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmp_pkg::res_t push_data,
  output logic          ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cmp_pkg::res_t out_data
);
  import cmp_pkg::*;

  res_t skid;
  logic skid_valid;
  logic pop;

  assign ready = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && !out_ready |=> skid_valid && out_valid)
    else $error("request taken during stall was not held");

endmodule
`default_nettype wire

// ===== test/coap_message_parser_tb.sv =====
// Self-checking testbench for the CoAP message parser: byte-level tag and summary checks.
module coap_message_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmp_pkg::*;

  localparam int URI_MAX     = 128;
  localparam int MAX_MESSAGE = 1500;
  // Cycles with no handshake on either side before the run is declared hung.
  // The long receiver hold-off below (HOLD_CYCLES) is far shorter, so this leaves ample margin.
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 240;

  // One request on the byte channel: a datagram byte and its end-of-message flag.
  typedef struct packed {
    logic [7:0] b;
    logic       eom;
  } request_t;

  logic clk;
  logic rst;

  cmp_byte_if   byte_stream();
  cmp_result_if result_stream();

  coap_message_parser #(
    .URI_MAX     (URI_MAX),
    .MAX_MESSAGE (MAX_MESSAGE)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .byte_stream   (byte_stream),
    .result_stream (result_stream)
  );

  // Requests waiting for the driver, and byte tags waiting for the monitor.
  request_t   request_q[$];
  res_t       byte_tags[$];
  logic [7:0] dg[$];          // datagram under construction

  int n_queued;               // requests handed to the driver
  int n_taken = 0;            // requests accepted by the block
  int n_errors = 0;
  int quiet;                  // watchdog: cycles since the last handshake
  int hold_left;              // receiver hold-off countdown
  bit hold_done;
  bit hold_armed;
  bit steady;                 // 1: neither side idles
  request_t next_req;

  // ---------------------------------------------------------------------------
  // Parser state, mirrored from the block's behavior
  // ---------------------------------------------------------------------------
  phase_t      ph;
  logic [1:0]  hdr_idx;
  logic [3:0]  tok_left;
  logic [3:0]  delta_nib;
  logic [3:0]  len_nib;
  logic [1:0]  ext_left;
  logic [15:0] ext_acc;
  logic [16:0] val_left;
  logic [15:0] opt_num;
  logic [7:0]  path_len;
  logic [1:0]  hdr_type;
  logic [3:0]  hdr_tkl;
  logic [7:0]  hdr_code;
  logic [15:0] hdr_mid;
  logic        parse_err;
  logic [10:0] pay_len;
  logic        seg_open;      // next value byte starts a new path segment
  logic [10:0] byte_cnt;

  function automatic void parser_clear();
    ph        = PH_HDR;
    hdr_idx   = '0;
    tok_left  = '0;
    delta_nib = '0;
    len_nib   = '0;
    ext_left  = '0;
    ext_acc   = '0;
    val_left  = '0;
    opt_num   = '0;
    path_len  = '0;
    hdr_type  = '0;
    hdr_tkl   = '0;
    hdr_code  = '0;
    hdr_mid   = '0;
    parse_err = 1'b0;
    pay_len   = '0;
    seg_open  = 1'b0;
    byte_cnt  = '0;
  endfunction

  // Running option number saturates instead of wrapping.
  function automatic void bump_option(int d);
    int s;
    s = int'(opt_num) + d;
    if (s > int'(OPT_NUM_MAX)) opt_num = OPT_NUM_MAX;
    else opt_num = s[15:0];
  endfunction

  function automatic void open_value(int n);
    val_left = n[16:0];
    seg_open = 1'b1;
    if (val_left != 0) ph = PH_VAL;
    else ph = PH_OPT;
  endfunction

  // Delta is settled; either fetch the length extension or start the value.
  function automatic void length_stage();
    if (len_nib >= NIB_EXT1) begin
      ext_left = (len_nib == NIB_EXT1) ? 2'd1 : 2'd2;
      ext_acc  = '0;
      ph       = PH_LEXT;
    end else begin
      open_value(int'(len_nib));
    end
  endfunction

  function automatic int ext_total(logic [3:0] nib);
    return ((nib == NIB_EXT1) ? int'(EXT1_BASE) : int'(EXT2_BASE)) + int'(ext_acc);
  endfunction

  // Predicts the tag for one accepted byte and advances the parser state.
  function automatic res_t tag_byte(logic [7:0] b, logic eom);
    res_t r;
    logic bad;
    r          = '0;
    r.role     = ROLE_IGNORED;
    r.data_out = b;
    if (byte_cnt >= MAX_MESSAGE) begin
      // oversized datagram: everything past the limit is dropped
      parse_err = 1'b1;
    end else begin
      byte_cnt++;
      case (ph)
        PH_HDR: begin
          r.role = ROLE_HDR;
          case (hdr_idx)
            2'd0: begin
              if (b[7:6] != COAP_VERSION || b[3:0] > TKL_MAX) parse_err = 1'b1;
              hdr_type = b[5:4];
              hdr_tkl  = b[3:0];
              tok_left = b[3:0];
            end
            2'd1: hdr_code = b;
            2'd2: hdr_mid[15:8] = b;
            default: hdr_mid[7:0] = b;
          endcase
          if (hdr_idx == 2'd3) begin
            // a bad header still gets captured, but the rest is ignored
            if (parse_err) ph = PH_IGN;
            else if (tok_left != 0) ph = PH_TOK;
            else ph = PH_OPT;
          end
          hdr_idx++;
        end
        PH_TOK: begin
          r.role   = ROLE_TOKEN;
          tok_left = tok_left - 4'd1;
          if (tok_left == 0) ph = PH_OPT;
        end
        PH_OPT: begin
          if (b == PAYLOAD_MARKER) begin
            r.role = ROLE_MARKER;
            ph     = PH_PAY;
          end else begin
            r.role    = ROLE_OPT_HDR;
            delta_nib = b[7:4];
            len_nib   = b[3:0];
            if (delta_nib == NIB_RESERVED || len_nib == NIB_RESERVED) begin
              parse_err = 1'b1;
              ph        = PH_IGN;
            end else if (delta_nib >= NIB_EXT1) begin
              ext_left = (delta_nib == NIB_EXT1) ? 2'd1 : 2'd2;
              ext_acc  = '0;
              ph       = PH_DEXT;
            end else begin
              bump_option(int'(delta_nib));
              length_stage();
            end
            r.option_number = opt_num;
          end
        end
        PH_DEXT, PH_LEXT: begin
          r.role   = ROLE_OPT_EXT;
          ext_acc  = {ext_acc[7:0], b};
          ext_left = ext_left - 2'd1;
          if (ext_left == 0) begin
            if (ph == PH_DEXT) begin
              bump_option(ext_total(delta_nib));
              length_stage();
            end else begin
              open_value(ext_total(len_nib));
            end
          end
          r.option_number = opt_num;
        end
        PH_VAL: begin
          r.role          = ROLE_OPT_VAL;
          r.option_number = opt_num;
          if (opt_num == URI_PATH_OPTION) begin
            // separator first, then the byte itself, each only if it still fits
            if (seg_open && path_len > 0 && int'(path_len) < URI_MAX - 1) begin
              r.uri_slash = 1'b1;
              path_len++;
            end
            if (int'(path_len) < URI_MAX - 1) begin
              r.uri_byte = 1'b1;
              path_len++;
            end
          end
          seg_open = 1'b0;
          val_left = val_left - 17'd1;
          if (val_left == 0) ph = PH_OPT;
        end
        PH_PAY: begin
          r.role = ROLE_PAYLOAD;
          if (pay_len < PAYLOAD_SAT) pay_len++;
        end
        default: r.role = ROLE_IGNORED;
      endcase
    end

    if (eom) begin
      // anything but a clean stop between options or inside a non-empty
      // payload counts as malformed
      bad = parse_err || (ph != PH_OPT && ph != PH_PAY) || (ph == PH_PAY && pay_len == 0);
      r.done_res       = 1'b1;
      r.malformed      = bad;
      r.msg_type       = hdr_type;
      r.token_length   = hdr_tkl;
      r.request_code   = hdr_code;
      r.message_id     = hdr_mid;
      r.payload_length = pay_len;
      parser_clear();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] ext_nib(int v);
    if (v < 13) return v[3:0];
    if (v < 269) return NIB_EXT1;
    return NIB_EXT2;
  endfunction

  task automatic push_ext(int v);
    int x;
    if (v >= 269) begin
      x = v - 269;
      dg.push_back(x[15:8]);
      dg.push_back(x[7:0]);
    end else if (v >= 13) begin
      x = v - 13;
      dg.push_back(x[7:0]);
    end
  endtask

  task automatic queue_datagram();
    foreach (dg[i]) begin
      request_q.push_back('{b: dg[i], eom: (i == dg.size() - 1)});
      n_queued++;
    end
  endtask

  // Mostly well-formed datagrams with random content; a third get broken.
  task automatic fill_random(int target);
    int added, tkl, d, len, cur, cut;
    added = 0;
    while (added < target) begin
      dg.delete();
      tkl = $urandom_range(0, 8);
      dg.push_back({COAP_VERSION, 2'($urandom_range(0, 3)), 4'(tkl)});
      repeat (3 + tkl) dg.push_back(8'($urandom));
      cur = 0;
      repeat ($urandom_range(0, 6)) begin
        // steer toward Uri-Path so repeated segments and a full path happen
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5: d = (cur <= 11) ? 11 - cur : 0;
          6, 7, 8, 9:       d = $urandom_range(0, 12);
          10, 11, 12:       d = $urandom_range(13, 268);
          13:               d = $urandom_range(269, 65804);
          default:          d = $urandom_range(0, 2);
        endcase
        case ($urandom_range(0, 15))
          0, 1:                      len = 0;
          2, 3, 4, 5, 6, 7, 8, 9:    len = $urandom_range(1, 12);
          10, 11, 12, 13, 14:        len = $urandom_range(13, 60);
          default:                   len = $urandom_range(269, 290);
        endcase
        cur = (cur + d > 65535) ? 65535 : cur + d;
        dg.push_back({ext_nib(d), ext_nib(len)});
        push_ext(d);
        push_ext(len);
        repeat (len) dg.push_back(8'($urandom));
      end
      if ($urandom_range(0, 2) != 0) begin
        dg.push_back(PAYLOAD_MARKER);
        repeat ($urandom_range(1, 40)) dg.push_back(8'($urandom));
      end
      case ($urandom_range(0, 11))
        0: begin  // cut short
          cut = $urandom_range(1, dg.size());
          while (dg.size() > cut) void'(dg.pop_back());
        end
        1: dg[$urandom_range(0, dg.size() - 1)] = 8'($urandom);
        2: repeat ($urandom_range(1, 3)) dg.push_back(8'($urandom));
        3: begin  // pure junk
          dg.delete();
          repeat ($urandom_range(1, 12)) dg.push_back(8'($urandom));
        end
        default: ;
      endcase
      queue_datagram();
      added += dg.size();
    end
  endtask

  // Sender pause: nothing new until every tag has come back.
  task automatic wait_drain();
    while (n_taken != n_queued || byte_tags.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, idles at random unless steady
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      byte_stream.valid     <= 1'b0;
      byte_stream.data_byte <= '0;
      byte_stream.last_byte <= 1'b0;
      parser_clear();
    end else begin
      if (byte_stream.valid && byte_stream.ready) begin
        byte_tags.push_back(tag_byte(byte_stream.data_byte, byte_stream.last_byte));
        n_taken++;
      end
      // only move on once the current request is gone (or none is offered)
      if (!byte_stream.valid || byte_stream.ready) begin
        if (request_q.size() > 0 && (steady || $urandom_range(0, 99) >= 34)) begin
          next_req = request_q.pop_front();
          byte_stream.valid     <= 1'b1;
          byte_stream.data_byte <= next_req.b;
          byte_stream.last_byte <= next_req.eom;
        end else begin
          byte_stream.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares every result with the oldest predicted tag
  // ---------------------------------------------------------------------------
  res_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_stream.ready <= 1'b0;
      hold_left           <= 0;
      hold_done           <= 1'b0;
    end else begin
      if (result_stream.valid && result_stream.ready) begin
        if (byte_tags.size() == 0) begin
          $display("%0t: unexpected result, expected none, got data_out %0d",
                   $time, result_stream.data_out);
          n_errors++;
        end else begin
          want = byte_tags.pop_front();
          check_field("role",           want.role,           result_stream.role);
          check_field("data_out",       want.data_out,       result_stream.data_out);
          check_field("option_number",  want.option_number,  result_stream.option_number);
          check_field("uri_byte",       want.uri_byte,       result_stream.uri_byte);
          check_field("uri_slash",      want.uri_slash,      result_stream.uri_slash);
          check_field("done_res",       want.done_res,       result_stream.done_res);
          check_field("malformed",      want.malformed,      result_stream.malformed);
          check_field("msg_type",       want.msg_type,       result_stream.msg_type);
          check_field("token_length",   want.token_length,   result_stream.token_length);
          check_field("request_code",   want.request_code,   result_stream.request_code);
          check_field("message_id",     want.message_id,     result_stream.message_id);
          check_field("payload_length", want.payload_length, result_stream.payload_length);
        end
      end
      // Long hold-off while the driver keeps offering: the result buffer
      // fills and the block must back-pressure its input.
      if (hold_left > 0) begin
        hold_left           <= hold_left - 1;
        result_stream.ready <= 1'b0;
      end else if (hold_armed && !hold_done && request_q.size() > 20) begin
        hold_left           <= HOLD_CYCLES;
        hold_done           <= 1'b1;
        result_stream.ready <= 1'b0;
      end else begin
        result_stream.ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog on handshake activity
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((byte_stream.valid && byte_stream.ready) ||
                 (result_stream.valid && result_stream.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    steady     = 1'b0;
    hold_armed = 1'b0;
    n_queued   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed datagrams.
    // lone zero byte: wrong version and the datagram stops inside the header
    dg = '{8'h00};
    queue_datagram();
    // all-ones header: bad version, token length 15; trailing byte ignored
    dg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    queue_datagram();
    // good request: token, empty Uri-Path, two path segments, payload
    dg = '{8'h41, 8'h01, 8'hAB, 8'hCD, 8'h5A,
           8'hB0,
           8'h02, 8'h61, 8'h62,
           8'h01, 8'h63,
           8'hFF, 8'h33};
    queue_datagram();
    // payload marker as the final byte
    dg = '{8'h50, 8'h00, 8'h00, 8'h00, 8'hFF};
    queue_datagram();
    // reserved length nibble in an option header
    dg = '{8'h60, 8'h02, 8'h00, 8'h01, 8'h1F, 8'h00};
    queue_datagram();
    wait_drain();

    // Random traffic with idling on both sides.
    fill_random(100);
    wait_drain();

    // Back-to-back stretch: no idling anywhere.
    steady <= 1'b1;
    fill_random(60);
    wait_drain();
    steady <= 1'b0;

    // Receiver hold-off, then an oversized datagram.
    hold_armed <= 1'b1;
    fill_random(80);
    dg = '{8'h40, 8'h00, 8'h00, 8'h00, PAYLOAD_MARKER};
    repeat (MAX_MESSAGE) dg.push_back(8'($urandom));
    queue_datagram();
    wait_drain();

    // idle on afterwards so that any stray result is still caught
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
